### hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the signed fixed-point ALU: opcode
// encoding, field widths and the control bundle that travels with an
// operation down the pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

	// Port field widths
	localparam int FIELD_W = 32;
	localparam int OP_W    = 4;

	// Default word format (Q24.8)
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 8;

	// Opcodes; codes above OP_TO_INT give a zero result
	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_MIN      = 4'd4,
		OP_MAX      = 4'd5,
		OP_INC      = 4'd6,
		OP_DEC      = 4'd7,
		OP_FROM_INT = 4'd8,
		OP_TO_INT   = 4'd9
	} op_t;

	// Per-operation control and early result, carried alongside the divider
	typedef struct packed {
		op_t                op;
		logic               less;
		logic               equal;
		logic               greater;
		logic               dbz;
		logic               ovf;
		logic               neg;
		logic [FIELD_W-1:0] res;
	} ctl_t;

endpackage

### hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Two-stage front end: compare, simple operations, the multiplier and the
// divider operand setup in the first stage; product scaling, multiply
// overflow and result selection in the second.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [OP_W-1:0]           req_type,
	input  logic signed [FIELD_W-1:0] operand_a,
	input  logic signed [FIELD_W-1:0] operand_b,
	output logic                      valid_out,
	output ctl_t                      ctl_out,
	output logic [WORD_BITS+FRAC_BITS-1:0] dvd_out,
	output logic [WORD_BITS-1:0]      dvs_out
);

	localparam int DP_W = WORD_BITS;
	localparam int FB   = FRAC_BITS;
	localparam int Q_W  = DP_W + FB;

	// Stage 1 combinational
	logic signed [DP_W-1:0]   a_w, b_w, simple;
	logic signed [2*DP_W-1:0] prod;
	logic [DP_W-1:0]          mag_a, mag_b;
	logic                     lt, eq, gt;
	op_t                      op;

	// Stage 1 registers
	logic                     valid_s1;
	op_t                      op_s1;
	logic                     less_s1, equal_s1, greater_s1, dbz_s1, neg_s1;
	logic signed [DP_W-1:0]   simple_s1;
	logic signed [2*DP_W-1:0] prod_s1;
	logic [Q_W-1:0]           dvd_s1;
	logic [DP_W-1:0]          dvs_s1;

	// Stage 2 combinational
	logic signed [2*DP_W-1:0] sh;
	logic signed [DP_W-1:0]   mul_res, res_w;
	logic                     mul_ovf;

	// Stage 2 registers
	logic                     valid_s2;
	ctl_t                     ctl_s2;
	logic [Q_W-1:0]           dvd_s2;
	logic [DP_W-1:0]          dvs_s2;

	// Operand decode and compare
	always_comb begin
		a_w   = operand_a[DP_W-1:0];
		b_w   = operand_b[DP_W-1:0];
		op    = op_t'(req_type);
		lt    = a_w < b_w;
		eq    = a_w == b_w;
		gt    = a_w > b_w;
		prod  = a_w * b_w;
		mag_a = a_w[DP_W-1] ? (~a_w + 1'b1) : a_w;
		mag_b = b_w[DP_W-1] ? (~b_w + 1'b1) : b_w;
	end

	// Simple operations; multiply and divide are finished later
	always_comb begin
		unique case (op)
			OP_ADD:      simple = a_w + b_w;
			OP_SUB:      simple = a_w - b_w;
			OP_MIN:      simple = lt ? a_w : b_w;
			OP_MAX:      simple = gt ? a_w : b_w;
			OP_INC:      simple = a_w + DP_W'(1);
			OP_DEC:      simple = a_w - DP_W'(1);
			OP_FROM_INT: simple = a_w <<< FB;
			OP_TO_INT:   simple = a_w >>> FB;
			default:     simple = '0;
		endcase
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1      <= op;
			less_s1    <= lt;
			equal_s1   <= eq;
			greater_s1 <= gt;
			dbz_s1     <= (op == OP_DIV) && (b_w == '0);
			neg_s1     <= a_w[DP_W-1] ^ b_w[DP_W-1];
			simple_s1  <= simple;
			prod_s1    <= prod;
			dvd_s1     <= {mag_a, {FB{1'b0}}};
			dvs_s1     <= mag_b;
		end
	end

	// Product scaling (floor shift) and range check
	always_comb begin
		sh      = prod_s1 >>> FB;
		mul_res = sh[DP_W-1:0];
		mul_ovf = !((&sh[2*DP_W-1:DP_W-1]) || !(|sh[2*DP_W-1:DP_W-1]));
		res_w   = (op_s1 == OP_MUL) ? mul_res : simple_s1;
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2.op      <= op_s1;
			ctl_s2.less    <= less_s1;
			ctl_s2.equal   <= equal_s1;
			ctl_s2.greater <= greater_s1;
			ctl_s2.dbz     <= dbz_s1;
			ctl_s2.ovf     <= (op_s1 == OP_MUL) && mul_ovf;
			ctl_s2.neg     <= neg_s1;
			ctl_s2.res     <= FIELD_W'(res_w);
			dvd_s2         <= dvd_s1;
			dvs_s2         <= dvs_s1;
		end
	end

	assign valid_out = valid_s2;
	assign ctl_out   = ctl_s2;
	assign dvd_out   = dvd_s2;
	assign dvs_out   = dvs_s2;

endmodule

### hdl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell
// One cell of the divider chain: develops one quotient bit of an unsigned
// restoring division and passes remainder, dividend/quotient shift word,
// divisor and the operation's control bundle to the next cell.
// ----------------------------------------------------------------------------
module fpa_div_cell import fpa_pkg::*; #(
	parameter int DP_W = WORD_BITS_DEF,
	parameter int Q_W  = WORD_BITS_DEF + FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  ctl_t            ctl_in,
	input  logic [DP_W-1:0] rem_in,
	input  logic [Q_W-1:0]  dvd_in,
	input  logic [DP_W-1:0] dvs_in,
	output logic            valid_out,
	output ctl_t            ctl_out,
	output logic [DP_W-1:0] rem_out,
	output logic [Q_W-1:0]  dvd_out,
	output logic [DP_W-1:0] dvs_out
);

	logic [DP_W-1:0] trial, rem_nx;
	logic            ge;

	logic            valid_q;
	ctl_t            ctl_q;
	logic [DP_W-1:0] rem_q, dvs_q;
	logic [Q_W-1:0]  dvd_q;

	// Shift in next dividend bit, trial subtract
	always_comb begin
		trial  = {rem_in[DP_W-2:0], dvd_in[Q_W-1]};
		ge     = trial >= dvs_in;
		rem_nx = ge ? (trial - dvs_in) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Quotient bit enters at the bottom as the dividend leaves at the top
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q <= ctl_in;
			rem_q <= rem_nx;
			dvd_q <= {dvd_in[Q_W-2:0], ge};
			dvs_q <= dvs_in;
		end
	end

	assign valid_out = valid_q;
	assign ctl_out   = ctl_q;
	assign rem_out   = rem_q;
	assign dvd_out   = dvd_q;
	assign dvs_out   = dvs_q;

endmodule

### hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Result stage: signs the quotient, checks its range, picks the final
// result and flags, and holds them in the output register.
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; #(
	parameter int DP_W = WORD_BITS_DEF,
	parameter int Q_W  = WORD_BITS_DEF + FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_in,
	input  ctl_t                      ctl_in,
	input  logic [Q_W-1:0]            quo_in,
	output logic                      out_valid,
	output logic signed [FIELD_W-1:0] result_value,
	output logic                      a_less,
	output logic                      a_equal,
	output logic                      a_greater,
	output logic                      divide_by_zero,
	output logic                      overflow
);

	logic [Q_W:0]           mag, qs;
	logic signed [DP_W-1:0] div_res;
	logic                   q_ovf, is_div;

	logic                     valid_q;
	logic [FIELD_W-1:0]       res_q;
	logic                     less_q, equal_q, greater_q, dbz_q, ovf_q;

	// Signed quotient and range check
	always_comb begin
		mag     = {1'b0, quo_in};
		qs      = ctl_in.neg ? (~mag + 1'b1) : mag;
		div_res = qs[DP_W-1:0];
		q_ovf   = !((&qs[Q_W:DP_W-1]) || !(|qs[Q_W:DP_W-1]));
		is_div  = (ctl_in.op == OP_DIV) && !ctl_in.dbz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			res_q     <= is_div ? FIELD_W'(div_res) : ctl_in.res;
			ovf_q     <= is_div ? q_ovf : ctl_in.ovf;
			dbz_q     <= ctl_in.dbz;
			less_q    <= ctl_in.less;
			equal_q   <= ctl_in.equal;
			greater_q <= ctl_in.greater;
		end
	end

	assign out_valid      = valid_q;
	assign result_value   = res_q;
	assign a_less         = less_q;
	assign a_equal        = equal_q;
	assign a_greater      = greater_q;
	assign divide_by_zero = dbz_q;
	assign overflow       = ovf_q;

endmodule

### hdl/fixed_point_q24_8_alu.sv
// Signed fixed-point ALU (default Q24.8). Every operation, divide included,
// goes down one fixed pipeline of Q_W + 3 stages: two front stages, one
// divider cell per quotient bit, and the output register. A new transfer
// is taken every cycle unless the pipeline holds; results leave in order.
// The whole pipeline holds while a finished result is stalled at the
// output, so in_stall follows out_stall whenever out_valid is high.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Top level: front end, chain of restoring divider cells, result stage and
// the shared pipeline advance.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu import fpa_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [OP_W-1:0]           req_type,
	input  logic signed [FIELD_W-1:0] operand_a,
	input  logic signed [FIELD_W-1:0] operand_b,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [FIELD_W-1:0] result_value,
	output logic                      a_less,
	output logic                      a_equal,
	output logic                      a_greater,
	output logic                      divide_by_zero,
	output logic                      overflow
);

	// Datapath width is the word clamped to 16..FIELD_W, fraction clamped to 1..16
	localparam int DP_W = (WORD_BITS > FIELD_W) ? FIELD_W : ((WORD_BITS < 16) ? 16 : WORD_BITS);
	localparam int FB   = (FRAC_BITS > 16) ? 16 : ((FRAC_BITS < 1) ? 1 : FRAC_BITS);
	localparam int Q_W  = DP_W + FB;

	logic en;

	logic            valid_c [0:Q_W];
	ctl_t            ctl_c   [0:Q_W];
	logic [DP_W-1:0] rem_c   [0:Q_W];
	logic [Q_W-1:0]  dvd_c   [0:Q_W];
	logic [DP_W-1:0] dvs_c   [0:Q_W];

	// Pipeline advances unless the output holds a stalled result
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign rem_c[0] = '0;

	fpa_front #(
		.WORD_BITS (DP_W),
		.FRAC_BITS (FB)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.valid_out (valid_c[0]),
		.ctl_out   (ctl_c[0]),
		.dvd_out   (dvd_c[0]),
		.dvs_out   (dvs_c[0])
	);

	// One divider cell per quotient bit
	for (genvar i = 0; i < Q_W; i++) begin : g_cell
		fpa_div_cell #(
			.DP_W (DP_W),
			.Q_W  (Q_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_c[i]),
			.ctl_in    (ctl_c[i]),
			.rem_in    (rem_c[i]),
			.dvd_in    (dvd_c[i]),
			.dvs_in    (dvs_c[i]),
			.valid_out (valid_c[i+1]),
			.ctl_out   (ctl_c[i+1]),
			.rem_out   (rem_c[i+1]),
			.dvd_out   (dvd_c[i+1]),
			.dvs_out   (dvs_c[i+1])
		);
	end

	fpa_back #(
		.DP_W (DP_W),
		.Q_W  (Q_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.valid_in       (valid_c[Q_W]),
		.ctl_in         (ctl_c[Q_W]),
		.quo_in         (dvd_c[Q_W]),
		.out_valid      (out_valid),
		.result_value   (result_value),
		.a_less         (a_less),
		.a_equal        (a_equal),
		.a_greater      (a_greater),
		.divide_by_zero (divide_by_zero),
		.overflow       (overflow)
	);

	// Exactly one compare flag per result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({a_less, a_equal, a_greater}))
		else $error("compare flags not one-hot");

	// Divide by zero gives a zero result and no overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_by_zero) |-> (result_value == '0) && !overflow)
		else $error("divide by zero result not clean");

	// Input is held off only by a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	// A stalled result does not leave the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(result_value))
		else $error("stalled result lost");

endmodule
